[design/nearest_oriented_box_lookup_defines.svh]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef NEAREST_ORIENTED_BOX_LOOKUP_DEFINES_SVH
`define NEAREST_ORIENTED_BOX_LOOKUP_DEFINES_SVH

// Same-cycle implication, off during reset.
`define NOBL_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off during reset.
`define NOBL_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication, live through reset.
`define NOBL_ASSERT_RST(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

[design/nobl_pkg.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: package
// Sizes, command codes and register indexes.
// ----------------------------------------------------------------------------
`default_nettype none
package nobl_pkg;
   localparam int MAX_BOXES  = 32;
   localparam int SLOT_W     = 5;
   localparam int ROW_W      = 2;
   localparam int ADDR_W     = SLOT_W + ROW_W;
   localparam int DEPTH      = MAX_BOXES * 4;
   localparam int COUNT_W    = 6;
   localparam int CSR_IDX_W  = 1;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   localparam logic [ROW_W-1:0] ROW_CENTRE = 2'd3;

   localparam logic [CSR_IDX_W-1:0] CSR_REACH = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_COUNT = 1'b1;
endpackage
`default_nettype wire

[design/nobl_req_if.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: request channel
// Load or query transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface nobl_req_if;
   logic                        valid;
   logic                        ready;
   logic                        command;
   logic [nobl_pkg::SLOT_W-1:0] box_slot;
   logic [nobl_pkg::ROW_W-1:0]  row_select;
   logic signed [31:0]          row_x;
   logic signed [31:0]          row_y;
   logic signed [31:0]          row_z;
   logic signed [31:0]          point_x;
   logic signed [31:0]          point_y;
   logic signed [31:0]          point_z;

   modport source (output valid, command, box_slot, row_select, row_x, row_y, row_z,
                   point_x, point_y, point_z, input ready);
   modport sink   (input valid, command, box_slot, row_select, row_x, row_y, row_z,
                   point_x, point_y, point_z, output ready);
endinterface
`default_nettype wire

[design/nobl_rsp_if.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: response channel
// Query result transaction with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface nobl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        found;
   logic [nobl_pkg::SLOT_W-1:0] nearest_slot;

   modport source (output valid, found, nearest_slot, input ready);
   modport sink   (input valid, found, nearest_slot, output ready);
endinterface
`default_nettype wire

[design/nobl_csr_if.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: register write channel
// Register index and write data with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface nobl_csr_if;
   logic                           valid;
   logic                           ready;
   logic [nobl_pkg::CSR_IDX_W-1:0] index;
   logic [31:0]                    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

[design/nearest_oriented_box_lookup.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup
// Box table in one synchronous memory, scanned by a shared-multiplier sequencer.
// ----------------------------------------------------------------------------
// Load: a centre row is written directly; an axis row takes 3 squares, 32 root steps and a write.
// Query: a centre read, the distance and up to three axis tests per examined box;
//   one transaction at a time, limited by the single memory read port and the
//   shared multiplier.
// Reset clears control, registers and the result valid; the table is undefined
//   until loaded and needs no clearing pass.
`default_nettype none
module nearest_oriented_box_lookup (
   input  wire         clock,
   input  wire         reset,
   nobl_req_if.sink    req_if,
   nobl_rsp_if.source  rsp_if,
   nobl_csr_if.sink    csr_if
);
   // sequencer codes
   localparam logic [4:0] ST_IDLE    = 5'd0;
   localparam logic [4:0] ST_LSQ_MUL = 5'd1;
   localparam logic [4:0] ST_LSQ_ACC = 5'd2;
   localparam logic [4:0] ST_LSQRT   = 5'd3;
   localparam logic [4:0] ST_LWRITE  = 5'd4;
   localparam logic [4:0] ST_CRD     = 5'd5;
   localparam logic [4:0] ST_REL     = 5'd6;
   localparam logic [4:0] ST_DMUL    = 5'd7;
   localparam logic [4:0] ST_DACC    = 5'd8;
   localparam logic [4:0] ST_ARD     = 5'd9;
   localparam logic [4:0] ST_ALEN    = 5'd10;
   localparam logic [4:0] ST_AMUL    = 5'd11;
   localparam logic [4:0] ST_AACC    = 5'd12;
   localparam logic [4:0] ST_RMUL    = 5'd13;
   localparam logic [4:0] ST_RCMP    = 5'd14;
   localparam logic [4:0] ST_HIT     = 5'd15;
   localparam logic [4:0] ST_NEXT    = 5'd16;
   localparam logic [4:0] ST_DONE    = 5'd17;

   localparam int SW = nobl_pkg::SLOT_W;
   localparam int CW = nobl_pkg::COUNT_W;

   // box table: {length, z, y, x} per row, rows 0..2 axes, row 3 centre
   logic [127:0] mem [nobl_pkg::DEPTH];
   logic [127:0] rd_data_ff;
   logic [nobl_pkg::ADDR_W-1:0] rd_addr;
   logic         rd_en;
   logic         wr_en;
   logic [127:0] wr_data;

   logic [4:0]  state_ff, state_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [1:0]  row_ff, row_in;
   logic [31:0] vec_ff [3];
   logic [31:0] vec_in [3];
   logic signed [32:0] rel_ff [3];
   logic signed [32:0] rel_in [3];
   logic [1:0]  j_ff, j_in, k_ff, k_in;
   logic [CW-1:0] box_ff, box_in, n_ff, n_in;
   logic signed [67:0] acc_ff, acc_in, prod_ff, prod, acc_sum, acc_abs;
   logic [63:0] dist_ff, dist_in, best_ff, best_in;
   logic [SW-1:0] best_slot_ff, best_slot_in;
   logic        found_ff, found_in;
   logic [63:0] v_ff, v_in, res_ff, res_in, bit_ff, bit_in, trial;
   logic [4:0]  iter_ff, iter_in;
   logic signed [31:0] reach_ff;
   logic [CW-1:0] count_ff;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        rsp_found_ff, rsp_found_in;
   logic [SW-1:0] rsp_slot_ff, rsp_slot_in;
   logic signed [33:0] mul_a, mul_b;
   logic [31:0] rd_comp, rd_len;
   logic        req_take;

   assign req_if.ready  = (state_ff == ST_IDLE);
   assign req_take      = req_if.valid && req_if.ready;
   assign csr_if.ready  = 1'b1;
   assign rsp_if.valid  = rsp_valid_ff;
   assign rsp_if.found  = rsp_found_ff;
   assign rsp_if.nearest_slot = rsp_slot_ff;

   assign rd_comp = rd_data_ff[j_ff*32 +: 32];
   assign rd_len  = rd_data_ff[127:96];
   assign acc_sum = acc_ff + prod_ff;
   assign acc_abs = acc_ff[67] ? -acc_ff : acc_ff;
   assign trial   = res_ff + bit_ff;

   // shared multiplier, product registered before use
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         ST_LSQ_MUL: begin
            mul_a = {{2{vec_ff[j_ff][31]}}, vec_ff[j_ff]};
            mul_b = mul_a;
         end
         ST_DMUL: begin
            mul_a = {rel_ff[j_ff][32], rel_ff[j_ff]};
            mul_b = mul_a;
         end
         ST_AMUL: begin
            mul_a = {rel_ff[j_ff][32], rel_ff[j_ff]};
            mul_b = {{2{rd_comp[31]}}, rd_comp};
         end
         ST_RMUL: begin
            // L * (L + reach)
            mul_a = {2'b00, rd_len};
            mul_b = {2'b00, rd_len} + {{2{reach_ff[31]}}, reach_ff};
         end
         default: ;
      endcase
   end
   assign prod = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      slot_in      = slot_ff;
      row_in       = row_ff;
      vec_in       = vec_ff;
      rel_in       = rel_ff;
      j_in         = j_ff;
      k_in         = k_ff;
      box_in       = box_ff;
      n_in         = n_ff;
      acc_in       = acc_ff;
      dist_in      = dist_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      v_in         = v_ff;
      res_in       = res_ff;
      bit_in       = bit_ff;
      iter_in      = iter_ff;
      rd_en        = 1'b0;
      rd_addr      = {box_ff[SW-1:0], k_ff};
      wr_en        = 1'b0;
      wr_data      = {(row_ff == nobl_pkg::ROW_CENTRE) ? 32'd0 : res_ff[31:0],
                      vec_ff[2], vec_ff[1], vec_ff[0]};
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_found_in = rsp_found_ff;
      rsp_slot_in  = rsp_slot_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               slot_in = req_if.box_slot;
               row_in  = req_if.row_select;
               j_in    = 2'd0;
               acc_in  = '0;
               if (req_if.command == nobl_pkg::CMD_LOAD) begin
                  vec_in[0] = req_if.row_x;
                  vec_in[1] = req_if.row_y;
                  vec_in[2] = req_if.row_z;
                  state_in  = (req_if.row_select == nobl_pkg::ROW_CENTRE) ?
                              ST_LWRITE : ST_LSQ_MUL;
               end else begin
                  vec_in[0]    = req_if.point_x;
                  vec_in[1]    = req_if.point_y;
                  vec_in[2]    = req_if.point_z;
                  box_in       = '0;
                  found_in     = 1'b0;
                  best_slot_in = '0;
                  best_in      = '0;
                  // clamp the scan to the table size
                  n_in = (count_ff > CW'(nobl_pkg::MAX_BOXES)) ?
                         CW'(nobl_pkg::MAX_BOXES) : count_ff;
                  state_in = (n_in == '0) ? ST_DONE : ST_CRD;
               end
            end
         end
         ST_LSQ_MUL: state_in = ST_LSQ_ACC;
         ST_LSQ_ACC: begin
            acc_in = acc_sum;
            if (j_ff == 2'd2) begin
               v_in     = acc_sum[63:0];
               res_in   = '0;
               bit_in   = 64'd1 << 62;
               iter_in  = '0;
               state_in = ST_LSQRT;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_LSQ_MUL;
            end
         end
         ST_LSQRT: begin
            // one root digit a cycle
            if (v_ff >= trial) begin
               v_in   = v_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in  = bit_ff >> 2;
            iter_in = iter_ff + 5'd1;
            if (iter_ff == 5'd31) state_in = ST_LWRITE;
         end
         ST_LWRITE: begin
            wr_en    = 1'b1;
            state_in = ST_IDLE;
         end
         ST_CRD: begin
            rd_en    = 1'b1;
            rd_addr  = {box_ff[SW-1:0], nobl_pkg::ROW_CENTRE};
            state_in = ST_REL;
         end
         ST_REL: begin
            for (int i = 0; i < 3; i++) begin
               rel_in[i] = $signed({vec_ff[i][31], vec_ff[i]}) -
                           $signed({rd_data_ff[i*32+31], rd_data_ff[i*32 +: 32]});
            end
            j_in     = 2'd0;
            acc_in   = '0;
            state_in = ST_DMUL;
         end
         ST_DMUL: state_in = ST_DACC;
         ST_DACC: begin
            acc_in = acc_sum;
            if (j_ff == 2'd2) begin
               // saturate the squared distance at 64 bits
               dist_in  = (acc_sum[67:64] != 4'd0) ? '1 : acc_sum[63:0];
               k_in     = 2'd0;
               state_in = ST_ARD;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_DMUL;
            end
         end
         ST_ARD: begin
            rd_en    = 1'b1;
            state_in = ST_ALEN;
         end
         ST_ALEN: begin
            j_in   = 2'd0;
            acc_in = '0;
            if (rd_len == 32'd0) begin
               // zero-length axis: unconstrained
               if (k_ff == 2'd2) begin
                  state_in = ST_HIT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_ARD;
               end
            end else begin
               state_in = ST_AMUL;
            end
         end
         ST_AMUL: state_in = ST_AACC;
         ST_AACC: begin
            acc_in = acc_sum;
            if (j_ff == 2'd2) begin
               state_in = ST_RMUL;
            end else begin
               j_in     = j_ff + 2'd1;
               state_in = ST_AMUL;
            end
         end
         ST_RMUL: state_in = ST_RCMP;
         ST_RCMP: begin
            if (acc_abs <= prod_ff) begin
               if (k_ff == 2'd2) begin
                  state_in = ST_HIT;
               end else begin
                  k_in     = k_ff + 2'd1;
                  state_in = ST_ARD;
               end
            end else begin
               state_in = ST_NEXT;
            end
         end
         ST_HIT: begin
            // strict compare keeps the lowest slot on a tie
            if (!found_ff || (dist_ff < best_ff)) begin
               found_in     = 1'b1;
               best_in      = dist_ff;
               best_slot_in = box_ff[SW-1:0];
            end
            state_in = ST_NEXT;
         end
         ST_NEXT: begin
            box_in   = box_ff + CW'(1);
            state_in = (box_in == n_ff) ? ST_DONE : ST_CRD;
         end
         ST_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = found_ff;
               rsp_slot_in  = best_slot_ff;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // table memory: one write and one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) mem[{slot_ff, row_ff}] <= wr_data;
      if (rd_en) rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         reach_ff     <= '0;
         count_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         found_ff     <= found_in;
         if (csr_if.valid && csr_if.ready) begin
            unique case (csr_if.index)
               nobl_pkg::CSR_REACH: reach_ff <= csr_if.data;
               nobl_pkg::CSR_COUNT: count_ff <= csr_if.data[CW-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      slot_ff      <= slot_in;
      row_ff       <= row_in;
      vec_ff       <= vec_in;
      rel_ff       <= rel_in;
      j_ff         <= j_in;
      k_ff         <= k_in;
      box_ff       <= box_in;
      n_ff         <= n_in;
      acc_ff       <= acc_in;
      prod_ff      <= prod;
      dist_ff      <= dist_in;
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      v_ff         <= v_in;
      res_ff       <= res_in;
      bit_ff       <= bit_in;
      iter_ff      <= iter_in;
      rsp_found_ff <= rsp_found_in;
      rsp_slot_ff  <= rsp_slot_in;
   end
endmodule
`default_nettype wire

[design/nobl_checker.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: port checker
// Checks response behaviour seen at the ports of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "nearest_oriented_box_lookup_defines.svh"
module nobl_checker (
   input wire                          clock,
   input wire                          reset,
   input wire                          req_valid,
   input wire                          req_ready,
   input wire                          rsp_valid,
   input wire                          rsp_ready,
   input wire                          rsp_found,
   input wire [nobl_pkg::SLOT_W-1:0]   rsp_nearest_slot
);
   // a stalled result holds
   `NOBL_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_found) && $stable(rsp_nearest_slot), "stalled result changed")
   // a miss reports slot zero
   `NOBL_ASSERT_NOW(a_miss_slot, rsp_valid && !rsp_found, rsp_nearest_slot == '0, "miss with non-zero slot")
   // no result appears right after a transaction is taken
   `NOBL_ASSERT_NEXT(a_no_early, req_valid && req_ready, !$rose(rsp_valid), "result too early")
   // reset drops the result
   `NOBL_ASSERT_RST(a_reset_idle, reset, !rsp_valid, "result valid after reset")
endmodule

bind nearest_oriented_box_lookup nobl_checker u_nobl_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_if.valid),
   .req_ready        (req_if.ready),
   .rsp_valid        (rsp_if.valid),
   .rsp_ready        (rsp_if.ready),
   .rsp_found        (rsp_if.found),
   .rsp_nearest_slot (rsp_if.nearest_slot)
);
`default_nettype wire

[bench/nearest_oriented_box_lookup_check.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: result checker
// Watches the request, response and register channels, keeps its own copy of
// the box table and registers, predicts each query result and compares it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nearest_oriented_box_lookup_check (
   input  wire   clock,
   input  wire   reset,
   nobl_req_if   req,
   nobl_rsp_if   rsp,
   nobl_csr_if   csr,
   output int    mismatch_count,
   output int    awaited_count
);
   typedef struct packed {
      logic                        found;
      logic [nobl_pkg::SLOT_W-1:0] slot;
   } lookup_type;

   logic signed [31:0]           tolerance;
   logic [nobl_pkg::COUNT_W-1:0] scan_count;
   logic signed [31:0] axis_vec [nobl_pkg::MAX_BOXES][3][3];
   logic signed [31:0] centre   [nobl_pkg::MAX_BOXES][3];
   logic [31:0]        half_len [nobl_pkg::MAX_BOXES][3];
   lookup_type         awaited_lookups [$];

   // Floor square root, one result bit per step from the top.
   function automatic logic [31:0] floor_root(logic [63:0] v);
      logic [31:0] r;
      logic [31:0] t;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         t = r | (32'd1 << b);
         if ({32'd0, t} * {32'd0, t} <= v) r = t;
      end
      return r;
   endfunction

   function automatic lookup_type nearest_box(logic signed [31:0] px,
                                              logic signed [31:0] py,
                                              logic signed [31:0] pz);
      lookup_type          best;
      logic [63:0]         best_d;
      logic [63:0]         d;
      logic signed [127:0] rel [3];
      logic signed [127:0] dsq, dot, lw, rhs;
      logic                enclosed;
      int                  n;
      best = '0;
      best_d = '0;
      n = (scan_count > nobl_pkg::MAX_BOXES) ? nobl_pkg::MAX_BOXES : scan_count;
      for (int s = 0; s < n; s++) begin
         rel[0] = longint'(px) - longint'(centre[s][0]);
         rel[1] = longint'(py) - longint'(centre[s][1]);
         rel[2] = longint'(pz) - longint'(centre[s][2]);
         dsq = rel[0] * rel[0] + rel[1] * rel[1] + rel[2] * rel[2];
         enclosed = 1'b1;
         for (int k = 0; k < 3; k++) begin
            if (half_len[s][k] != 0) begin
               dot = '0;
               for (int j = 0; j < 3; j++) dot += rel[j] * 128'(axis_vec[s][k][j]);
               if (dot < 0) dot = -dot;
               lw = {96'd0, half_len[s][k]};
               rhs = lw * (lw + 128'(tolerance));
               if (dot > rhs) enclosed = 1'b0;
            end
         end
         d = (dsq[127:64] != 0) ? '1 : dsq[63:0];
         if (enclosed && (!best.found || d < best_d)) begin
            best.found = 1'b1;
            best.slot = s[nobl_pkg::SLOT_W-1:0];
            best_d = d;
         end
      end
      return best;
   endfunction

   always @(posedge clock) begin
      lookup_type  got, want;
      logic [63:0] sum;
      logic [63:0] m;
      if (reset) begin
         tolerance = '0;
         scan_count = '0;
         mismatch_count = 0;
         awaited_lookups.delete();
      end else begin
         if (csr.valid && csr.ready) begin
            if (csr.index == nobl_pkg::CSR_REACH) tolerance = csr.data;
            else if (csr.index == nobl_pkg::CSR_COUNT)
               scan_count = csr.data[nobl_pkg::COUNT_W-1:0];
         end
         if (req.valid && req.ready) begin
            if (req.command == nobl_pkg::CMD_LOAD) begin
               if (req.row_select == nobl_pkg::ROW_CENTRE) begin
                  centre[req.box_slot][0] = req.row_x;
                  centre[req.box_slot][1] = req.row_y;
                  centre[req.box_slot][2] = req.row_z;
               end else begin
                  axis_vec[req.box_slot][req.row_select][0] = req.row_x;
                  axis_vec[req.box_slot][req.row_select][1] = req.row_y;
                  axis_vec[req.box_slot][req.row_select][2] = req.row_z;
                  sum = '0;
                  for (int j = 0; j < 3; j++) begin
                     m = longint'(axis_vec[req.box_slot][req.row_select][j]);
                     if (m[63]) m = -m;
                     sum += m * m;
                  end
                  half_len[req.box_slot][req.row_select] = floor_root(sum);
               end
            end else begin
               awaited_lookups = {awaited_lookups,
                                  nearest_box(req.point_x, req.point_y, req.point_z)};
            end
         end
         if (rsp.valid && rsp.ready) begin
            got.found = rsp.found;
            got.slot = rsp.nearest_slot;
            if (awaited_lookups.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("%0t: result with none awaited: found=%0b slot=%0d",
                           $realtime, got.found, got.slot);
            end else begin
               want = awaited_lookups.pop_front();
               if (got.found !== want.found || got.slot !== want.slot) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("%0t: found exp %0b got %0b, slot exp %0d got %0d",
                              $realtime, want.found, got.found, want.slot, got.slot);
               end
            end
         end
      end
      awaited_count = awaited_lookups.size();
   end
endmodule

[bench/nearest_oriented_box_lookup_test.sv]
// ----------------------------------------------------------------------------
// Nearest oriented box lookup: testbench top
// Fills the box table, runs directed loads and queries, then random phases
// under several register settings with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module nearest_oriented_box_lookup_test;
   localparam int SW = nobl_pkg::SLOT_W;
   localparam int RW = nobl_pkg::ROW_W;
   localparam int NB = nobl_pkg::MAX_BOXES;

   logic clock = 1'b0;
   logic reset = 1'b1;
   int   mismatch_count;
   int   awaited_count;
   int   quiet_cycles;
   logic calm = 1'b0;          // no idling on either side while set
   logic hold_request = 1'b0;  // ask the receiver for one long hold-off
   logic hold_done = 1'b0;
   int   hold_left = 0;
   logic signed [31:0] centre_copy [NB][3];

   nobl_req_if req_ch();
   nobl_rsp_if rsp_ch();
   nobl_csr_if csr_ch();

   nearest_oriented_box_lookup dut (
      .clock(clock), .reset(reset), .req_if(req_ch), .rsp_if(rsp_ch), .csr_if(csr_ch)
   );

   nearest_oriented_box_lookup_check checker_inst (
      .clock(clock), .reset(reset), .req(req_ch), .rsp(rsp_ch), .csr(csr_ch),
      .mismatch_count(mismatch_count), .awaited_count(awaited_count)
   );

   always #5 clock = ~clock;

   // Receiver: random back-pressure, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_request && !hold_done) begin
         rsp_ch.ready <= 1'b0;
         hold_left <= 3000;
         hold_done <= 1'b1;
      end else begin
         rsp_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 37);
      end
   end

   // Watchdog: end the run when nothing moves for too long.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (csr_ch.valid && csr_ch.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= 20000) begin
            $display("Mismatches found");
            $finish;
         end
      end
   end

   // Leave the request channel idle now and then, for a random span.
   task automatic maybe_pause();
      if (!calm && $urandom_range(99) < 37) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   // Offer one transaction and hold it until accepted; valid stays high after.
   task automatic send_request(logic cmd, logic [SW-1:0] slot, logic [RW-1:0] row,
                               logic [31:0] x, logic [31:0] y, logic [31:0] z);
      maybe_pause();
      req_ch.command    <= cmd;
      req_ch.box_slot   <= slot;
      req_ch.row_select <= row;
      req_ch.row_x      <= x;
      req_ch.row_y      <= y;
      req_ch.row_z      <= z;
      req_ch.point_x    <= x;
      req_ch.point_y    <= y;
      req_ch.point_z    <= z;
      req_ch.valid      <= 1'b1;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      if (cmd == nobl_pkg::CMD_LOAD && row == nobl_pkg::ROW_CENTRE) begin
         centre_copy[slot][0] = x;
         centre_copy[slot][1] = y;
         centre_copy[slot][2] = z;
      end
   endtask

   // Wait for every awaited result, then let any load in flight finish.
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (awaited_count != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_register(logic [nobl_pkg::CSR_IDX_W-1:0] idx, logic [31:0] value);
      csr_ch.index <= idx;
      csr_ch.data  <= value;
      csr_ch.valid <= 1'b1;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      csr_ch.valid <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [31:0] pick_component();
      case ($urandom_range(3))
         0: return $urandom;
         1: return ($urandom_range(1, 8) << 16) * ($urandom_range(1) ? 1 : -1);
         2: case ($urandom_range(3))
               0: return 32'h8000_0000;
               1: return 32'h7fff_ffff;
               2: return 32'h0;
               default: return 32'hffff_ffff;
            endcase
         default: return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      endcase
   endfunction

   // Axis rows; the first axis of a box is never all zero so no box is empty.
   task automatic load_axis(logic [SW-1:0] slot, logic [RW-1:0] row);
      logic [31:0] c [3];
      do begin
         foreach (c[j]) c[j] = ($urandom_range(3) == 0) ? 32'h0 : pick_component();
      end while (row == 0 && c[0] == 0 && c[1] == 0 && c[2] == 0);
      send_request(nobl_pkg::CMD_LOAD, slot, row, c[0], c[1], c[2]);
   endtask

   task automatic load_centre(logic [SW-1:0] slot);
      if ($urandom_range(4) == 0)
         send_request(nobl_pkg::CMD_LOAD, slot, nobl_pkg::ROW_CENTRE,
                      $urandom, $urandom, $urandom);
      else
         send_request(nobl_pkg::CMD_LOAD, slot, nobl_pkg::ROW_CENTRE,
                      $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000,
                      $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000,
                      $signed($urandom_range(0, 32'h0080_0000)) - 32'sh0040_0000);
   endtask

   // Mostly points close to a loaded centre, so boxes do contain them.
   task automatic random_query();
      logic [31:0] p [3];
      int          s;
      s = $urandom_range(NB - 1);
      case ($urandom_range(9))
         0, 1: foreach (p[j]) p[j] = $urandom;
         2:    foreach (p[j]) p[j] = pick_component();
         default: foreach (p[j])
            p[j] = centre_copy[s][j] + $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      endcase
      send_request(nobl_pkg::CMD_QUERY, '0, '0, p[0], p[1], p[2]);
   endtask

   logic [31:0] reach_set [8] = '{32'h0, 32'h7fff_ffff, 32'h8000_0000, 32'h0001_0000,
                                   32'hffff_0000, 32'h0, 32'h0010_0000, 32'h0000_8000};
   logic [31:0] count_set [8] = '{32'd32, 32'd1, 32'd63, 32'd0, 32'd8, 32'd17, 32'd32, 32'd5};

   initial begin
      req_ch.valid = 1'b0;
      req_ch.command = nobl_pkg::CMD_LOAD;
      req_ch.box_slot = '0;
      req_ch.row_select = '0;
      req_ch.row_x = '0;
      req_ch.row_y = '0;
      req_ch.row_z = '0;
      req_ch.point_x = '0;
      req_ch.point_y = '0;
      req_ch.point_z = '0;
      csr_ch.valid = 1'b0;
      csr_ch.index = nobl_pkg::CSR_REACH;
      csr_ch.data = '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Fill every slot so that any box count reads written entries only.
      for (int s = 0; s < NB; s++) begin
         load_axis(SW'(s), 2'd0);
         load_axis(SW'(s), 2'd1);
         load_axis(SW'(s), 2'd2);
         load_centre(SW'(s));
      end
      drain();
      write_register(nobl_pkg::CSR_REACH, 32'h0);
      write_register(nobl_pkg::CSR_COUNT, 32'd32);

      // Directed: two identical unit boxes for a tie, a zero-length axis,
      // extreme axis components, and extreme query points.
      for (int s = 3; s <= 5; s += 2) begin
         send_request(nobl_pkg::CMD_LOAD, SW'(s), 2'd0, 32'h0001_0000, 32'h0, 32'h0);
         send_request(nobl_pkg::CMD_LOAD, SW'(s), 2'd1, 32'h0, 32'h0, 32'h0);
         send_request(nobl_pkg::CMD_LOAD, SW'(s), 2'd2, 32'h0, 32'h0, 32'h0001_0000);
         send_request(nobl_pkg::CMD_LOAD, SW'(s), nobl_pkg::ROW_CENTRE,
                      32'h7000_0000, 32'h7000_0000, 32'h7000_0000);
      end
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'h7000_0000, 32'h7000_0000, 32'h7000_0000);
      send_request(nobl_pkg::CMD_LOAD, 5'd31, 2'd2, 32'h8000_0000, 32'h7fff_ffff,
                   32'h8000_0000);
      send_request(nobl_pkg::CMD_LOAD, 5'd30, 2'd0, 32'h7fff_ffff, 32'h7fff_ffff,
                   32'h7fff_ffff);
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'h0, 32'h0, 32'h0);
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_request(nobl_pkg::CMD_QUERY, '0, '0, 32'h7000_0100, 32'h7000_0000, 32'h6fff_ff00);
      drain();

      // Random phases, each under its own register setting.
      for (int ph = 0; ph < 8; ph++) begin
         write_register(nobl_pkg::CSR_REACH, (ph == 5) ? $urandom : reach_set[ph]);
         write_register(nobl_pkg::CSR_COUNT, count_set[ph]);
         calm <= (ph == 4);
         if (ph == 2) hold_request <= 1'b1;
         for (int n = 0; n < 80; n++) begin
            if ($urandom_range(99) < 45) begin
               random_query();
            end else begin
               if ($urandom_range(3) == 0) load_centre(SW'($urandom_range(NB - 1)));
               else load_axis(SW'($urandom_range(NB - 1)), RW'($urandom_range(2)));
            end
         end
         drain();
      end

      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end
endmodule
